/* sv/qstp_pkg.sv */
`default_nettype none

package qstp_pkg;

	// field widths
	localparam int unsigned CompW = 16;
	localparam int unsigned MagW  = 17;
	localparam int unsigned CodeW = 15;
	localparam int unsigned UW    = 15;
	localparam int unsigned NumW  = 28;
	localparam int unsigned ProdW = 42;
	localparam int unsigned QuoW  = 14;
	localparam int unsigned KeptN = 3;
	localparam int unsigned CompN = 4;

	// quantizer constants: 1/sqrt2 in Q2.14, its double, code ceiling
	localparam int unsigned QsRange   = 11585;
	localparam int unsigned QsSpan    = 23170;
	localparam int unsigned QsCodeMax = 32767;
	// 32767 = 23170 + 9597, so code = u + (u*9597 + 11585) / 23170
	localparam int unsigned QsRemMul  = 9597;
	// floor(2^28 / 23170), quotient estimate is exact or one low for n < 2^28
	localparam int unsigned QsRecip      = 11585;
	localparam int unsigned QsRecipShift = 28;

	typedef logic signed [CompW-1:0] comp_t;
	typedef logic [1:0]              idx_t;
	typedef logic [CodeW-1:0]        code_t;

	// per-stage load enables of the quantizer lanes
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} lane_en_t;

endpackage

`default_nettype wire

/* sv/quaternion_smallest_three_pack_core.sv */
// Smallest-three quaternion packer.
// Input channel: comp_x, comp_y, comp_z, comp_w (signed Q2.14) with
// comp_valid / comp_stall; a beat is taken when comp_valid is high and
// comp_stall is low.
// Output channel: packed_word (48 bits: dropped index in [47:46], three
// 15-bit codes, bit 0 zero) with packed_valid / packed_stall.
// One beat is taken every cycle while the output is not stalled; the
// pipeline runs through a register after the largest-component search
// and then the three quantizer lanes, each with a remainder multiply,
// a reciprocal multiply and a correction stage.
// A stalled output holds its word; bubbles in the pipeline still close up
// behind it, and comp_stall rises only once every stage holds a beat.
// Reset (arst_n low) empties the pipeline; the data registers are not reset.
`default_nettype none

module quaternion_smallest_three_pack_core
	import qstp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   comp_valid,
	output logic                   comp_stall,
	input  logic signed [CompW-1:0] comp_x,
	input  logic signed [CompW-1:0] comp_y,
	input  logic signed [CompW-1:0] comp_z,
	input  logic signed [CompW-1:0] comp_w,
	output logic                   packed_valid,
	input  logic                   packed_stall,
	output logic [47:0]            packed_word
);

	comp_t    comp_in [CompN];
	comp_t    comp_s1 [CompN];
	comp_t    kept [KeptN];
	code_t    code_s5 [KeptN];
	idx_t     big;
	logic     neg;
	idx_t     big_s1;
	idx_t     big_s2;
	idx_t     big_s3;
	idx_t     big_s4;
	idx_t     big_s5;
	logic     neg_s1;
	logic     v_s1;
	logic     v_s2;
	logic     v_s3;
	logic     v_s4;
	logic     v_s5;
	logic     rdy1;
	logic     rdy2;
	logic     rdy3;
	logic     rdy4;
	logic     rdy5;
	lane_en_t lane_en;

	assign comp_in[0] = comp_x;
	assign comp_in[1] = comp_y;
	assign comp_in[2] = comp_z;
	assign comp_in[3] = comp_w;

	// ready chain, a stage loads when empty or when its successor moves
	always_comb begin
		rdy5 = !v_s5 || !packed_stall;
		rdy4 = !v_s4 || rdy5;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
	end

	assign comp_stall = !rdy1;
	assign lane_en    = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	// valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= comp_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// largest-magnitude search over the four components
	qstp_select u_select (
		.comp (comp_in),
		.big  (big),
		.neg  (neg)
	);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			comp_s1 <= comp_in;
			big_s1  <= big;
			neg_s1  <= neg;
		end
	end

	// route the three kept components to the lanes in index order
	always_comb begin
		kept[0] = (big_s1 == 2'd0) ? comp_s1[1] : comp_s1[0];
		kept[1] = (big_s1 == 2'd0 || big_s1 == 2'd1) ? comp_s1[2] : comp_s1[1];
		kept[2] = (big_s1 == 2'd3) ? comp_s1[2] : comp_s1[3];
	end

	for (genvar g = 0; g < KeptN; g++) begin : g_lane
		qstp_quant_lane u_lane (
			.clk     (clk),
			.en      (lane_en),
			.comp    (kept[g]),
			.neg     (neg_s1),
			.code_s5 (code_s5[g])
		);
	end

	// dropped index travels alongside the lanes
	always_ff @(posedge clk) begin
		if (rdy2) big_s2 <= big_s1;
		if (rdy3) big_s3 <= big_s2;
		if (rdy4) big_s4 <= big_s3;
		if (rdy5) big_s5 <= big_s4;
	end

	assign packed_valid = v_s5;
	assign packed_word  = {big_s5, code_s5[0], code_s5[1], code_s5[2], 1'b0};

	// input stalls only when the first stage holds a beat
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		comp_stall |-> v_s1)
		else $error("input stalled with empty first stage");

	// a beat in stage s4 reaches the output when the output is not stalled
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !packed_stall) |=> packed_valid)
		else $error("beat lost between lane stage and output");

	// low pad bit of the code word stays clear
	a_pad_bit: assert property (@(posedge clk) disable iff (!arst_n)
		packed_valid |-> (packed_word[0] == 1'b0))
		else $error("pad bit set in packed word");

endmodule

`default_nettype wire

/* sv/qstp_select.sv */
`default_nettype none

module qstp_select
	import qstp_pkg::*;
(
	input  comp_t comp [CompN],
	output idx_t  big,
	output logic  neg
);

	logic [MagW-1:0] mag [CompN];
	idx_t            win_lo;
	idx_t            win_hi;
	logic [MagW-1:0] mag_lo;
	logic [MagW-1:0] mag_hi;

	// magnitude per lane at full precision so -32768 gives 32768
	always_comb begin
		for (int i = 0; i < CompN; i++) begin
			if (comp[i][CompW-1]) begin
				mag[i] = MagW'(-$signed({comp[i][CompW-1], comp[i]}));
			end else begin
				mag[i] = MagW'(comp[i]);
			end
		end
	end

	// pairwise compare tree, lower index keeps a tie
	always_comb begin
		if (mag[1] > mag[0]) begin
			win_lo = 2'd1;
			mag_lo = mag[1];
		end else begin
			win_lo = 2'd0;
			mag_lo = mag[0];
		end
		if (mag[3] > mag[2]) begin
			win_hi = 2'd3;
			mag_hi = mag[3];
		end else begin
			win_hi = 2'd2;
			mag_hi = mag[2];
		end
		if (mag_hi > mag_lo) begin
			big = win_hi;
		end else begin
			big = win_lo;
		end
		neg = comp[big][CompW-1];
	end

endmodule

`default_nettype wire

/* sv/qstp_quant_lane.sv */
`default_nettype none

module qstp_quant_lane
	import qstp_pkg::*;
(
	input  logic     clk,
	input  lane_en_t en,
	input  comp_t    comp,
	input  logic     neg,
	output code_t    code_s5
);

	logic signed [MagW-1:0] c_full;
	logic signed [MagW-1:0] c_clamp;
	logic [UW-1:0]          u_s2;
	logic [UW-1:0]          u_s3;
	logic [UW-1:0]          u_s4;
	logic [NumW:0]          n_full;
	logic [NumW-1:0]        n_s3;
	logic [NumW-1:0]        n_s4;
	logic [ProdW-1:0]       p_s4;
	logic [QuoW-1:0]        q_est;
	logic [NumW-1:0]        q_back;
	logic [NumW-1:0]        rem;
	logic                   corr;
	logic [CodeW:0]         sum;

	// sign fold and clamp to +/-1/sqrt2, then shift to 0..23170
	always_comb begin
		c_full = neg ? -$signed({comp[CompW-1], comp}) : $signed({comp[CompW-1], comp});
		if (c_full > $signed(MagW'(QsRange))) begin
			c_clamp = $signed(MagW'(QsRange));
		end else if (c_full < -$signed(MagW'(QsRange))) begin
			c_clamp = -$signed(MagW'(QsRange));
		end else begin
			c_clamp = c_full;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			u_s2 <= UW'(c_clamp + $signed(MagW'(QsRange)));
		end
	end

	// numerator of the fractional part of the code
	assign n_full = (NumW+1)'(u_s2) * (NumW+1)'(QsRemMul) + (NumW+1)'(QsRange);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			u_s3 <= u_s2;
			n_s3 <= n_full[NumW-1:0];
		end
	end

	// reciprocal multiply for the divide by 23170
	always_ff @(posedge clk) begin
		if (en.s4) begin
			u_s4 <= u_s3;
			n_s4 <= n_s3;
			p_s4 <= ProdW'(n_s3) * ProdW'(QsRecip);
		end
	end

	// one-step correction of the estimate, then add the integer part
	always_comb begin
		q_est  = p_s4[QsRecipShift +: QuoW];
		q_back = NumW'(q_est) * NumW'(QsSpan);
		rem    = n_s4 - q_back;
		corr   = rem >= NumW'(QsSpan);
		sum    = (CodeW+1)'(u_s4) + (CodeW+1)'(q_est) + (CodeW+1)'(corr);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (sum > (CodeW+1)'(QsCodeMax)) begin
				code_s5 <= CodeW'(QsCodeMax);
			end else begin
				code_s5 <= sum[CodeW-1:0];
			end
		end
	end

endmodule

`default_nettype wire
